FILE: hdl/bds_pkg.sv
// bds_pkg: shared types, constants and coordinate helpers for the box difference splitter
// no dependencies; imported by every module in hdl/

package bds_pkg;

   localparam int DIMS          = 2;
   localparam int COORD_BITS    = 32;
   localparam int FIELD_BITS    = 32;
   localparam int CARRIED_DIMS  = 2;
   localparam int MAX_RESULTS   = 2 * CARRIED_DIMS;
   localparam int SLOT_BITS     = $clog2(MAX_RESULTS);
   localparam int WIDE_BITS     = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [FIELD_BITS-1:0] field_type;
   typedef coord_type   [CARRIED_DIMS-1:0] coord_vec_type;

   typedef struct packed {
      coord_vec_type lo;
      coord_vec_type hi;
   } box_type;

   // all pieces of one difference, slot order: upper/lower slab per dimension
   typedef struct packed {
      box_type [MAX_RESULTS-1:0] box;
      logic    [MAX_RESULTS-1:0] valid;
      logic                      no_box;
   } carve_type;

   typedef struct packed {
      box_type box;
      logic    is_last;
      logic    no_box;
   } result_type;

   // field word to internal coordinate, sign-extended or cut to COORD_BITS
   function automatic coord_type to_coord(field_type x);
      logic signed [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(signed'(x));
      return w[COORD_BITS-1:0];
   endfunction

   // internal coordinate back to a field word
   function automatic field_type from_coord(coord_type c);
      logic signed [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(c);
      return w[FIELD_BITS-1:0];
   endfunction

endpackage

FILE: hdl/bds_carve.sv
// bds_carve: combinational split of box A minus box B into up to four disjoint slabs
// depends on bds_pkg

module bds_carve import bds_pkg::*; (
   input  box_type   a,
   input  box_type   b,
   output carve_type carve
);

   always_comb begin
      coord_vec_type ilo;
      coord_vec_type ihi;
      coord_vec_type rlo;
      coord_vec_type rhi;
      logic          empty;
      logic          same;

      empty = 1'b0;
      same  = 1'b1;
      for (int d = 0; d < CARRIED_DIMS; d++) begin
         ilo[d] = ($signed(a.lo[d]) < $signed(b.lo[d])) ? b.lo[d] : a.lo[d];
         ihi[d] = ($signed(b.hi[d]) < $signed(a.hi[d])) ? b.hi[d] : a.hi[d];
         if (d < DIMS) begin
            if ($signed(ihi[d]) < $signed(ilo[d])) empty = 1'b1;
            if (ilo[d] != a.lo[d] || ihi[d] != a.hi[d]) same = 1'b0;
         end
      end

      rlo   = a.lo;
      rhi   = a.hi;
      carve = '0;
      if (empty) begin
         carve.box[0]   = a;
         carve.valid[0] = 1'b1;
      end else if (same) begin
         carve.valid[0] = 1'b1;
         carve.no_box   = 1'b1;
      end else begin
         for (int d = 0; d < CARRIED_DIMS; d++) begin
            if (d < DIMS) begin
               // upper slab first, then lower, remainder shrinks each time
               if ($signed(ihi[d]) < $signed(rhi[d])) begin
                  carve.box[2*d].lo    = rlo;
                  carve.box[2*d].hi    = rhi;
                  carve.box[2*d].lo[d] = ihi[d] + coord_type'(1);
                  carve.valid[2*d]     = 1'b1;
                  rhi[d]               = ihi[d];
               end
               if ($signed(rlo[d]) < $signed(ilo[d])) begin
                  carve.box[2*d+1].lo    = rlo;
                  carve.box[2*d+1].hi    = rhi;
                  carve.box[2*d+1].hi[d] = ilo[d] - coord_type'(1);
                  carve.valid[2*d+1]     = 1'b1;
                  rlo[d]                 = ilo[d];
               end
            end
         end
      end
   end

endmodule

FILE: hdl/bds_result_queue.sv
// bds_result_queue: holds the pieces of one item and sends them one word per cycle while out_ready is high
// depends on bds_pkg

module bds_result_queue import bds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  carve_type  carve,
   output logic       take,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_word
);

   carve_type              carve_ff;
   carve_type              carve_in;
   logic [MAX_RESULTS-1:0] mask_ff;
   logic [MAX_RESULTS-1:0] mask_in;
   logic [SLOT_BITS-1:0]   sel;
   logic                   sent;

   always_comb begin
      sel = '0;
      for (int i = MAX_RESULTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) sel = SLOT_BITS'(i);
      end
   end

   assign out_valid        = |mask_ff;
   assign sent             = out_valid && out_ready;
   // bank is free or its final word leaves this cycle
   assign take             = in_valid && (!out_valid || (sent && $onehot(mask_ff)));
   assign out_word.box     = carve_ff.box[sel];
   assign out_word.is_last = $onehot(mask_ff);
   assign out_word.no_box  = carve_ff.no_box;

   always_comb begin
      carve_in = carve_ff;
      mask_in  = mask_ff;
      if (take) begin
         carve_in = carve;
         mask_in  = carve.valid;
      end else if (sent) begin
         mask_in = mask_ff & ~(MAX_RESULTS'(1) << sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      carve_ff <= carve_in;
   end

endmodule

FILE: hdl/box_difference_splitter.sv
// box_difference_splitter: axis-aligned box difference A minus B, top level
// depends on bds_pkg, bds_carve, bds_result_queue
//
// Takes boxes A and B (inclusive bounds, two dimensions) and returns A minus B as one to four
// disjoint boxes, one result word per cycle while rsp_ready is high, the final one flagged
// rsp_is_last. A disjoint B gives A back whole; a B covering A gives one word with rsp_no_box
// set and zero bounds. The input word is registered in the input stage, then carved and
// loaded into the result bank, from which the words are sent. The next input is taken while
// the current pieces drain, and its pieces follow the last one with no gap.

module box_difference_splitter import bds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_a_low_0,
   input  logic [31:0] req_a_high_0,
   input  logic [31:0] req_a_low_1,
   input  logic [31:0] req_a_high_1,
   input  logic [31:0] req_b_low_0,
   input  logic [31:0] req_b_high_0,
   input  logic [31:0] req_b_low_1,
   input  logic [31:0] req_b_high_1,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_low_0,
   output logic [31:0] rsp_out_high_0,
   output logic [31:0] rsp_out_low_1,
   output logic [31:0] rsp_out_high_1,
   output logic        rsp_is_last,
   output logic        rsp_no_box
);

   logic       s1_valid_ff;
   logic       s1_valid_in;
   box_type    a_ff;
   box_type    a_in;
   box_type    b_ff;
   box_type    b_in;
   carve_type  carve;
   logic       take;
   result_type word;
   logic       req_fire;

   assign req_ready = !s1_valid_ff || take;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         a_in.lo[0]  = to_coord(req_a_low_0);
         a_in.hi[0]  = to_coord(req_a_high_0);
         a_in.lo[1]  = to_coord(req_a_low_1);
         a_in.hi[1]  = to_coord(req_a_high_1);
         b_in.lo[0]  = to_coord(req_b_low_0);
         b_in.hi[0]  = to_coord(req_b_high_0);
         b_in.lo[1]  = to_coord(req_b_low_1);
         b_in.hi[1]  = to_coord(req_b_high_1);
         s1_valid_in = 1'b1;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   bds_carve u_carve (
      .a     (a_ff),
      .b     (b_ff),
      .carve (carve)
   );

   bds_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .carve     (carve),
      .take      (take),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (word)
   );

   // dimensions beyond DIMS read as zero
   assign rsp_out_low_0  = (DIMS > 0) ? from_coord(word.box.lo[0]) : '0;
   assign rsp_out_high_0 = (DIMS > 0) ? from_coord(word.box.hi[0]) : '0;
   assign rsp_out_low_1  = (DIMS > 1) ? from_coord(word.box.lo[1]) : '0;
   assign rsp_out_high_1 = (DIMS > 1) ? from_coord(word.box.hi[1]) : '0;
   assign rsp_is_last    = word.is_last;
   assign rsp_no_box     = word.no_box;

   // an empty difference is always a single word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_box |-> rsp_is_last)
      else $error("no_box word not marked last");

   // a new item only replaces the bank when its final word leaves
   assert property (@(posedge clock) disable iff (reset)
      take && rsp_valid |-> rsp_ready && rsp_is_last)
      else $error("result bank overwritten before drained");

   // input stage keeps its item until the bank takes it
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !take |=> s1_valid_ff)
      else $error("input stage item lost");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not idle after reset");

endmodule
